@@ rtl/thbp_pkg.sv @@
// Package with shared types, codes and fixed constants of the thermostat band controller.
package thbp_pkg;

   // Fixed field widths
   localparam int CENTI_W    = 14;
   localparam int MEAS_W     = 15;
   localparam int OFFSET_W   = 11;
   localparam int LIMIT_W    = 15;
   localparam int CSR_DATA_W = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int DUTY_W     = 7;
   localparam int CMP_W      = 10;

   // Divider sizing: numerator is diff*100 (diff <= 10000), quotient below 128
   localparam int DIV_W  = 20;
   localparam int QUO_W  = 7;
   localparam int STEP_W = 3;

   // Job queue between front and back end
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;
   localparam int PIPE_CNT_W = 3;

   // Arithmetic constants
   localparam logic [CENTI_W-1:0] CENTI_FULL_SCALE  = 14'd10000;
   localparam logic [CENTI_W-1:0] BAND_PAD_CENTI    = 14'd10;
   localparam logic [DUTY_W-1:0]  DUTY_MAX          = 7'd100;
   localparam logic [DUTY_W-1:0]  DUTY_ON_THRESHOLD = 7'd10;

   // Divide by 100 as multiply by ceil(2^30/100), exact below 14.1e6
   localparam int             RECIP_W     = 24;
   localparam int             RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

   // Register reset values
   localparam logic signed [OFFSET_W-1:0] CFG_OFFSET_RESET    = 11'sd0;
   localparam logic signed [LIMIT_W-1:0]  CFG_SAFE_HIGH_RESET = 15'sd5000;
   localparam logic signed [LIMIT_W-1:0]  CFG_SAFE_LOW_RESET  = -15'sd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_OFFSET = 2'd0,
      CSR_SAFE_HIGH   = 2'd1,
      CSR_SAFE_LOW    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_INSIDE = 2'd0,
      STATUS_ABOVE  = 2'd1,
      STATUS_BELOW  = 2'd2
   } band_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_PROD,
      BK_SCALE,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] temp_offset;
      logic signed [LIMIT_W-1:0]  safe_high;
      logic signed [LIMIT_W-1:0]  safe_low;
   } cfg_type;

   // Classified item handed from front to back end
   typedef struct packed {
      band_status_type           status;
      logic                      range_error;
      logic signed [MEAS_W-1:0]  meas;
      logic [CENTI_W-1:0]        diff;
      logic [CENTI_W-1:0]        divisor;
   } job_type;

   // Queue status seen by the top level and back end
   typedef struct packed {
      logic                  empty;
      logic [FIFO_CNT_W-1:0] count;
   } fifo_status_type;

endpackage

@@ rtl/thbp_intf.sv @@
// Valid/ready channel interfaces for input readings and result beats.
interface thbp_req_if #(parameter int ADC_BITS = 12) ();
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] measured_raw;
   logic [ADC_BITS-1:0] setpoint_raw;
   logic [ADC_BITS-1:0] band_raw;

   modport source (output valid, measured_raw, setpoint_raw, band_raw, input ready);
   modport sink   (input valid, measured_raw, setpoint_raw, band_raw, output ready);
endinterface

interface thbp_rsp_if ();
   logic              valid;
   logic              ready;
   logic [1:0]        band_status;
   logic [6:0]        duty_percent;
   logic [9:0]        compare_value;
   logic              compressor_on;
   logic              range_error;
   logic signed [14:0] measured_centi;

   modport source (output valid, band_status, duty_percent, compare_value, compressor_on,
                   range_error, measured_centi, input ready);
   modport sink   (input valid, band_status, duty_percent, compare_value, compressor_on,
                   range_error, measured_centi, output ready);
endinterface

@@ rtl/thermostat_band_pwm_controller.sv @@
// Path of a beat: 4 front stages, the queue write, then the back-end states idle, product,
// scale and emit outside the band, with the 7-step divide between idle and product inside it.
// The back end pops a new job only from idle, after emitting the last one, and emit waits for a
// free output register; the front takes a beat a cycle while the 8-entry queue has credit.
// Synchronous active-high reset empties the pipeline and queue and loads register defaults:
// offset 0, upper safe limit 5000, lower safe limit -1000 centidegrees.
module thermostat_band_pwm_controller
   import thbp_pkg::*;
#(
   parameter int ADC_BITS   = 12,
   parameter int PWM_PERIOD = 999
) (
   input  logic                  clock,
   input  logic                  reset,
   thbp_req_if.sink              req_chan,
   thbp_rsp_if.source            rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type               cfg_ff;
   logic                  accept_ok;
   logic                  job_valid;
   job_type               job;
   logic [PIPE_CNT_W-1:0] pipe_count;
   logic                  pop;
   job_type               head;
   fifo_status_type       fifo_status;
   logic [FIFO_CNT_W:0]   credit_used;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_offset <= CFG_OFFSET_RESET;
         cfg_ff.safe_high   <= CFG_SAFE_HIGH_RESET;
         cfg_ff.safe_low    <= CFG_SAFE_LOW_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TEMP_OFFSET: cfg_ff.temp_offset <= csr_write_data[OFFSET_W-1:0];
            CSR_SAFE_HIGH:   cfg_ff.safe_high   <= csr_write_data[LIMIT_W-1:0];
            CSR_SAFE_LOW:    cfg_ff.safe_low    <= csr_write_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Admit a beat only while queue slots cover every job still in flight
   assign credit_used = (FIFO_CNT_W + 1)'(fifo_status.count) + (FIFO_CNT_W + 1)'(pipe_count);
   assign accept_ok   = credit_used < (FIFO_CNT_W + 1)'(FIFO_DEPTH);

   thbp_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .accept_ok  (accept_ok),
      .cfg        (cfg_ff),
      .job_valid  (job_valid),
      .job        (job),
      .pipe_count (pipe_count)
   );

   thbp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .status   (fifo_status)
   );

   thbp_back #(
      .PWM_PERIOD (PWM_PERIOD)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

@@ rtl/thbp_front.sv @@
// Front end: accepts readings, scales them to centidegrees and classifies against the band.
module thbp_front
   import thbp_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   thbp_req_if.sink              req_chan,
   input  logic                  accept_ok,
   input  cfg_type               cfg,
   output logic                  job_valid,
   output job_type               job,
   output logic [PIPE_CNT_W-1:0] pipe_count
);

   localparam int PROD_W = ADC_BITS + CENTI_W;
   localparam int R_W    = ((ADC_BITS > CENTI_W) ? ADC_BITS : CENTI_W) + 1;
   localparam logic [R_W-1:0] ADC_MAX = R_W'((1 << ADC_BITS) - 1);
   localparam int NCH    = 3;

   logic                 accept;
   logic [ADC_BITS-1:0]  raw [NCH];
   logic [3:0]           valid_ff;
   logic [PROD_W-1:0]    prod_ff [NCH];
   logic [CENTI_W-1:0]   q0_ff [NCH];
   logic [R_W-1:0]       r1_ff [NCH];
   logic [CENTI_W-1:0]   centi_ff [NCH];
   logic [R_W-1:0]       q1 [NCH];
   logic [R_W-1:0]       r2 [NCH];
   job_type              job_ff;

   logic signed [16:0] meas_s, setp_s, band_s, hi_s, lo_s, upper_s, lower_s, diff_s;
   logic               above, below, err;
   job_type            job_in;

   assign accept         = req_chan.valid && accept_ok;
   assign req_chan.ready = accept_ok;
   assign raw[0] = req_chan.measured_raw;
   assign raw[1] = req_chan.setpoint_raw;
   assign raw[2] = req_chan.band_raw;

   // Advance stage valid bits; the pipeline never stalls, the queue credit covers it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], accept};
      end
   end

   // Scale each code: raw*10000/(2^B-1) by folding the high part back twice
   for (genvar c = 0; c < NCH; c++) begin : g_scale
      assign q1[c] = r1_ff[c] >> ADC_BITS;
      assign r2[c] = R_W'(r1_ff[c][ADC_BITS-1:0]) + q1[c];

      always_ff @(posedge clock) begin
         prod_ff[c]  <= PROD_W'(raw[c]) * PROD_W'(CENTI_FULL_SCALE);
         q0_ff[c]    <= CENTI_W'(prod_ff[c] >> ADC_BITS);
         r1_ff[c]    <= R_W'(prod_ff[c][ADC_BITS-1:0])
                        + R_W'(prod_ff[c] >> ADC_BITS);
         centi_ff[c] <= CENTI_W'(R_W'(q0_ff[c]) + q1[c] + R_W'(r2[c] >= ADC_MAX));
      end
   end

   // Classify against band and safe limits
   always_comb begin
      meas_s  = {3'b000, centi_ff[0]} - {{6{cfg.temp_offset[OFFSET_W-1]}}, cfg.temp_offset};
      setp_s  = {3'b000, centi_ff[1]};
      band_s  = {3'b000, centi_ff[2]};
      hi_s    = {{2{cfg.safe_high[LIMIT_W-1]}}, cfg.safe_high};
      lo_s    = {{2{cfg.safe_low[LIMIT_W-1]}}, cfg.safe_low};
      upper_s = setp_s + band_s;
      lower_s = setp_s - band_s;
      diff_s  = meas_s - setp_s;
      above   = meas_s > upper_s;
      below   = meas_s < lower_s;
      err     = (meas_s > hi_s) || (meas_s < lo_s);

      job_in.range_error = err;
      job_in.meas        = meas_s[MEAS_W-1:0];
      job_in.divisor     = centi_ff[2] + BAND_PAD_CENTI;
      job_in.diff        = '0;
      if (above) begin
         job_in.status = STATUS_ABOVE;
      end else if (below) begin
         job_in.status = STATUS_BELOW;
      end else begin
         job_in.status = STATUS_INSIDE;
         if (!diff_s[16]) begin
            job_in.diff = diff_s[CENTI_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid  = valid_ff[3];
   assign job        = job_ff;
   assign pipe_count = PIPE_CNT_W'($countones(valid_ff));

endmodule

@@ rtl/thbp_fifo.sv @@
// Short job queue decoupling the classifying front end from the duty back end.
module thbp_fifo
   import thbp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  job_type         push_job,
   input  logic            pop,
   output job_type         head,
   output fifo_status_type status
);

   job_type               slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

@@ rtl/thbp_back.sv @@
// Back end: divides for proportional duty, scales the timer compare and drives result beats.
module thbp_back
   import thbp_pkg::*;
#(
   parameter int PWM_PERIOD = 999
) (
   input  logic            clock,
   input  logic            reset,
   input  job_type         head,
   input  fifo_status_type fifo_status,
   output logic            pop,
   thbp_rsp_if.source      rsp_chan
);

   localparam int PWM_W   = $clog2(PWM_PERIOD + 1);
   localparam int PROD_W  = DUTY_W + PWM_W;
   localparam int SCALE_W = (PROD_W + RECIP_W > RECIP_SHIFT + CMP_W) ?
                            PROD_W + RECIP_W : RECIP_SHIFT + CMP_W;

   back_state_type      state_ff, state_in;
   job_type             job_ff, job_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;

   logic                rsp_valid_ff, rsp_valid_in;
   band_status_type     rsp_status_ff, rsp_status_in;
   logic [DUTY_W-1:0]   rsp_duty_ff, rsp_duty_in;
   logic [CMP_W-1:0]    rsp_cmp_ff, rsp_cmp_in;
   logic                rsp_comp_ff, rsp_comp_in;
   logic                rsp_err_ff, rsp_err_in;
   logic signed [MEAS_W-1:0] rsp_meas_ff, rsp_meas_in;

   logic [DIV_W-1:0]    shifted;
   logic                fits;
   logic [QUO_W-1:0]    quo_next;

   // Sequence one job: divide (inside the band only), multiply by period, divide by 100, emit
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      duty_in       = duty_ff;
      prod_in       = prod_ff;
      scale_in      = scale_ff;
      pop           = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_cmp_in    = rsp_cmp_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_meas_in   = rsp_meas_ff;

      shifted  = DIV_W'(job_ff.divisor) << step_ff;
      fits     = rem_ff >= shifted;
      quo_next = {quo_ff[QUO_W-2:0], fits};

      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_status.empty) begin
               pop     = 1'b1;
               job_in  = head;
               rem_in  = DIV_W'(head.diff) * DIV_W'(DUTY_MAX);
               quo_in  = '0;
               step_in = STEP_W'(QUO_W - 1);
               if (head.status == STATUS_INSIDE) begin
                  state_in = BK_DIV;
               end else begin
                  duty_in  = (head.status == STATUS_ABOVE) ? DUTY_MAX : '0;
                  state_in = BK_PROD;
               end
            end
         end
         BK_DIV: begin
            // one quotient bit a cycle; quotient stays below 128 as diff <= band
            if (fits) begin
               rem_in = rem_ff - shifted;
            end
            quo_in  = quo_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               duty_in  = (quo_next > DUTY_MAX) ? DUTY_MAX : quo_next;
               state_in = BK_PROD;
            end
         end
         BK_PROD: begin
            prod_in  = PROD_W'(duty_ff) * PROD_W'(PWM_PERIOD);
            state_in = BK_SCALE;
         end
         BK_SCALE: begin
            scale_in = SCALE_W'(prod_ff) * SCALE_W'(RECIP_100);
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = job_ff.status;
               rsp_duty_in   = duty_ff;
               rsp_cmp_in    = job_ff.range_error ? '0 : scale_ff[RECIP_SHIFT +: CMP_W];
               rsp_comp_in   = (job_ff.status == STATUS_ABOVE) ||
                               ((job_ff.status == STATUS_INSIDE) &&
                                (duty_ff > DUTY_ON_THRESHOLD));
               rsp_err_in    = job_ff.range_error;
               rsp_meas_in   = job_ff.meas;
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      duty_ff       <= duty_in;
      prod_ff       <= prod_in;
      scale_ff      <= scale_in;
      rsp_status_ff <= rsp_status_in;
      rsp_duty_ff   <= rsp_duty_in;
      rsp_cmp_ff    <= rsp_cmp_in;
      rsp_comp_ff   <= rsp_comp_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_meas_ff   <= rsp_meas_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.band_status    = rsp_status_ff;
   assign rsp_chan.duty_percent   = rsp_duty_ff;
   assign rsp_chan.compare_value  = rsp_cmp_ff;
   assign rsp_chan.compressor_on  = rsp_comp_ff;
   assign rsp_chan.range_error    = rsp_err_ff;
   assign rsp_chan.measured_centi = rsp_meas_ff;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the thermostat band controller: directed, random and stall tests.
module testbench
   import thbp_pkg::*;
();

   // Scaling and duty constants of the controller
   localparam int ADC_FULL_CODE = 4095;
   localparam int CENTI_SPAN    = 10000;
   localparam int DUTY_FULL     = 100;
   localparam int DUTY_ON_LEVEL = 10;
   localparam int BAND_PAD      = 10;
   localparam int PWM_TOP       = 999;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 30;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_CAP    = 40;

   typedef struct packed {
      band_status_type          status;
      logic [DUTY_W-1:0]        duty;
      logic [CMP_W-1:0]         compare;
      logic                     compressor;
      logic                     fault;
      logic signed [MEAS_W-1:0] meas;
   } drive_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   thbp_req_if #(.ADC_BITS(12)) req_chan ();
   thbp_rsp_if                  rsp_chan ();

   thermostat_band_pwm_controller #(
      .ADC_BITS   (12),
      .PWM_PERIOD (PWM_TOP)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the register file
   int offset_centi;
   int high_limit;
   int low_limit;

   drive_word_type awaited_drives[$];
   int             mismatch_count;
   int             cycle_count;
   bit             src_idle_on;
   bit             sink_idle_on;
   int             hold_left;

   always #10 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < REPORT_CAP)
         $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic int scale_centi(int raw);
      return (raw * CENTI_SPAN) / ADC_FULL_CODE;
   endfunction

   // Work out the controller outputs for one set of readings
   function automatic drive_word_type compute_drive(int m_raw, int s_raw, int b_raw);
      drive_word_type d;
      int             meas;
      int             setp;
      int             band;
      int             diff;
      int             duty;
      int             cmp;
      logic           fault;
      meas = scale_centi(m_raw) - offset_centi;
      setp = scale_centi(s_raw);
      band = scale_centi(b_raw);
      if (meas > setp + band) begin
         d.status     = STATUS_ABOVE;
         duty         = DUTY_FULL;
         d.compressor = 1'b1;
      end else if (meas < setp - band) begin
         d.status     = STATUS_BELOW;
         duty         = 0;
         d.compressor = 1'b0;
      end else begin
         diff = (meas > setp) ? meas - setp : 0;
         duty = (diff * DUTY_FULL) / (band + BAND_PAD);
         if (duty > DUTY_FULL)
            duty = DUTY_FULL;
         d.compressor = (duty > DUTY_ON_LEVEL);
         d.status     = STATUS_INSIDE;
      end
      fault     = (meas > high_limit) || (meas < low_limit);
      cmp       = fault ? 0 : (duty * PWM_TOP) / DUTY_FULL;
      d.fault   = fault;
      d.duty    = duty[DUTY_W-1:0];
      d.compare = cmp[CMP_W-1:0];
      d.meas    = meas[MEAS_W-1:0];
      return d;
   endfunction

   // Offer one beat, with an optional idle burst first, and hold until taken
   task automatic send_reading(int m_raw, int s_raw, int b_raw);
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.measured_raw <= m_raw[11:0];
      req_chan.setpoint_raw <= s_raw[11:0];
      req_chan.band_raw     <= b_raw[11:0];
      do @(posedge clock); while (!req_chan.ready);
      awaited_drives.push_back(compute_drive(m_raw, s_raw, b_raw));
   endtask

   // Mostly readings near the band so the proportional region gets exercised
   task automatic send_random_reading();
      int s_raw;
      int b_raw;
      int m_raw;
      int spread;
      s_raw = $urandom_range(0, ADC_FULL_CODE);
      if ($urandom_range(0, 2) == 0) begin
         b_raw = $urandom_range(0, ADC_FULL_CODE);
         m_raw = $urandom_range(0, ADC_FULL_CODE);
      end else begin
         b_raw  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 600);
         spread = b_raw + 20;
         m_raw  = s_raw + $urandom_range(0, 2 * spread) - spread;
         if (m_raw < 0)
            m_raw = 0;
         if (m_raw > ADC_FULL_CODE)
            m_raw = ADC_FULL_CODE;
      end
      send_reading(m_raw, s_raw, b_raw);
   endtask

   // Drop valid and wait for every outstanding result beat
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (awaited_drives.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, int value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_TEMP_OFFSET: offset_centi = $signed(value[OFFSET_W-1:0]);
         CSR_SAFE_HIGH:   high_limit   = $signed(value[LIMIT_W-1:0]);
         CSR_SAFE_LOW:    low_limit    = $signed(value[LIMIT_W-1:0]);
         default: ;
      endcase
   endtask

   // Check each result beat and pace the sink side
   initial begin : result_checker
      drive_word_type want;
      int             stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_drives.size() == 0) begin
               report_mismatch("result beat with none awaited", 1, 0);
            end else begin
               want = awaited_drives.pop_front();
               if (rsp_chan.band_status !== want.status)
                  report_mismatch("band_status", rsp_chan.band_status, want.status);
               if (rsp_chan.duty_percent !== want.duty)
                  report_mismatch("duty_percent", rsp_chan.duty_percent, want.duty);
               if (rsp_chan.compare_value !== want.compare)
                  report_mismatch("compare_value", rsp_chan.compare_value, want.compare);
               if (rsp_chan.compressor_on !== want.compressor)
                  report_mismatch("compressor_on", rsp_chan.compressor_on, want.compressor);
               if (rsp_chan.range_error !== want.fault)
                  report_mismatch("range_error", rsp_chan.range_error, want.fault);
               if (rsp_chan.measured_centi !== want.meas)
                  report_mismatch("measured_centi", int'(rsp_chan.measured_centi),
                                  int'(want.meas));
            end
         end
         // Long hold-off first, then short random stalls
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Field extremes under the reset register values
   task automatic test_reset_defaults();
      send_reading(0, 0, 0);
      send_reading(ADC_FULL_CODE, ADC_FULL_CODE, ADC_FULL_CODE);
      send_reading(ADC_FULL_CODE, 0, 0);
      send_reading(0, ADC_FULL_CODE, 0);
      send_reading(0, 0, ADC_FULL_CODE);
      send_reading(2048, 2048, 0);
      send_reading('hAAA, 'h555, 'h0F0);
   endtask

   // Hit both band edges exactly, one step past each, and a zero band
   task automatic test_band_edges();
      int edge_off;
      edge_off = scale_centi(2000) - scale_centi(1600) - scale_centi(400);
      write_register(CSR_TEMP_OFFSET, edge_off);
      send_reading(2000, 1600, 400);
      write_register(CSR_TEMP_OFFSET, edge_off - 1);
      send_reading(2000, 1600, 400);
      edge_off = scale_centi(1200) - scale_centi(1600) + scale_centi(400);
      write_register(CSR_TEMP_OFFSET, edge_off);
      send_reading(1200, 1600, 400);
      write_register(CSR_TEMP_OFFSET, edge_off + 1);
      send_reading(1200, 1600, 400);
      write_register(CSR_TEMP_OFFSET, 0);
      send_reading(1000, 1000, 0);
      send_reading(1001, 1000, 0);
   endtask

   // Safe limits: equality, one past, crossed limits and an unused index
   task automatic test_safe_limits();
      write_register(CSR_SAFE_HIGH, scale_centi(2048));
      send_reading(2048, 2048, 0);
      write_register(CSR_SAFE_HIGH, scale_centi(2048) - 1);
      send_reading(2048, 2048, 0);
      write_register(CSR_SAFE_HIGH, 16383);
      write_register(CSR_SAFE_LOW, scale_centi(2048));
      send_reading(2048, 1000, 500);
      write_register(CSR_SAFE_LOW, scale_centi(2048) + 1);
      send_reading(2048, 1000, 500);
      write_register(CSR_SAFE_LOW, 3000);
      write_register(CSR_SAFE_HIGH, 2000);
      send_reading(1024, 1024, 100);
      send_reading(3000, 1024, 100);
      write_register(CSR_UNUSED_INDEX, 'h7FFF);
      send_reading(1024, 1024, 100);
   endtask

   // Random readings across several register settings, extremes included
   task automatic test_random_sweep();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_TEMP_OFFSET, 0);
               write_register(CSR_SAFE_HIGH, 5000);
               write_register(CSR_SAFE_LOW, -1000);
            end
            1: begin
               // Upper bits of the offset word carry junk that must be dropped
               write_register(CSR_TEMP_OFFSET, 'h7C00);
               write_register(CSR_SAFE_HIGH, 16383);
               write_register(CSR_SAFE_LOW, -16384);
            end
            2: begin
               write_register(CSR_TEMP_OFFSET, 1023);
               write_register(CSR_SAFE_HIGH, -16384);
               write_register(CSR_SAFE_LOW, 16383);
            end
            3: begin
               write_register(CSR_TEMP_OFFSET, $urandom_range(0, 32767));
               write_register(CSR_SAFE_HIGH, $urandom_range(0, 12000) - 1000);
               write_register(CSR_SAFE_LOW, $urandom_range(0, 13000) - 2000);
            end
            default: begin
               write_register(CSR_TEMP_OFFSET, $urandom_range(0, 2000) - 1000);
               write_register(CSR_SAFE_HIGH, 11000);
               write_register(CSR_SAFE_LOW, -2000);
            end
         endcase
         repeat (80) send_random_reading();
      end
   endtask

   // Hold the sink off long enough for the input to stall
   task automatic test_backpressure();
      drain_results();
      hold_left = 300;
      repeat (40) send_random_reading();
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_steady_stream();
      drain_results();
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      repeat (60) send_random_reading();
   endtask

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.measured_raw = '0;
      req_chan.setpoint_raw = '0;
      req_chan.band_raw     = '0;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      offset_centi          = 0;
      high_limit            = 5000;
      low_limit             = -1000;
      mismatch_count        = 0;
      cycle_count           = 0;
      hold_left             = 0;
      src_idle_on           = 1'b1;
      sink_idle_on          = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_band_edges();
      test_safe_limits();
      test_random_sweep();
      test_backpressure();
      test_steady_stream();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_drives.size() != 0)
         report_mismatch("result beats never returned", 0, awaited_drives.size());
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/thbp_pkg.sv
rtl/thbp_intf.sv
rtl/thbp_front.sv
rtl/thbp_fifo.sv
rtl/thbp_back.sv
rtl/thermostat_band_pwm_controller.sv
test/testbench.sv
